### hdl/statement_completeness_checker_core_assert.svh
// ----------------------------------------------------------------------------
// statement completeness checker assertion macros
// shared forms for the concurrent checks of the core and its scanner
// ----------------------------------------------------------------------------
`ifndef STATEMENT_COMPLETENESS_CHECKER_CORE_ASSERT_SVH
`define STATEMENT_COMPLETENESS_CHECKER_CORE_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define SCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define SCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// shared constants and types of the statement completeness checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

    localparam int DEPTH_BITS_DEF = 16;

    localparam logic [7:0] CHR_NUL    = 8'h00;
    localparam logic [7:0] CHR_LF     = 8'h0a;
    localparam logic [7:0] CHR_CR     = 8'h0d;
    localparam logic [7:0] CHR_SPACE  = 8'h20;
    localparam logic [7:0] CHR_DQUOTE = 8'h22;
    localparam logic [7:0] CHR_SQUOTE = 8'h27;
    localparam logic [7:0] CHR_LPAREN = 8'h28;
    localparam logic [7:0] CHR_RPAREN = 8'h29;
    localparam logic [7:0] CHR_COLON  = 8'h3a;
    localparam logic [7:0] CHR_BSLASH = 8'h5c;

    typedef enum logic [1:0] {
        WHY_COMPLETE    = 2'd0,
        WHY_OPEN_GROUP  = 2'd1,
        WHY_TRAIL_COLON = 2'd2,
        WHY_OPEN_BLOCK  = 2'd3
    } why_t;

    typedef struct packed {
        logic complete;
        why_t why;
    } verdict_t;

endpackage

`default_nettype wire

### hdl/scc_scan.sv
// ----------------------------------------------------------------------------
// scc_scan
// per-byte state update for quotes, parentheses, colon and indentation,
// and the verdict formed from that state when the buffer ends
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "statement_completeness_checker_core_assert.svh"

module scc_scan
    import scc_pkg::*;
#(
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic [7:0] text_byte,
    output verdict_t        verdict
);

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = {{(DEPTH_BITS-1){1'b0}}, 1'b1};

    logic [DEPTH_BITS-1:0] paren_depth_reg, paren_depth_next;
    logic in_quote_reg, in_quote_next;
    logic quote_dq_reg, quote_dq_next;
    logic escape_reg, escape_next;
    logic colon_reg, colon_next;
    logic line_start_reg, line_start_next;
    logic line_ind_reg, line_ind_next;
    logic last_ind_reg, last_ind_next;
    logic saw_ind_reg, saw_ind_next;

    logic terminator;
    logic depth_open;

    assign terminator = (text_byte == CHR_NUL);
    assign depth_open = !paren_depth_reg[DEPTH_BITS-1] && (paren_depth_reg != '0);

    always_comb begin
        if (depth_open || in_quote_reg) begin
            verdict.why = WHY_OPEN_GROUP;
        end else if (colon_reg) begin
            verdict.why = WHY_TRAIL_COLON;
        end else if (saw_ind_reg && last_ind_reg) begin
            verdict.why = WHY_OPEN_BLOCK;
        end else begin
            verdict.why = WHY_COMPLETE;
        end
        verdict.complete = (verdict.why == WHY_COMPLETE);
    end

    // quote and parenthesis tracking
    always_comb begin
        paren_depth_next = paren_depth_reg;
        in_quote_next    = in_quote_reg;
        quote_dq_next    = quote_dq_reg;
        escape_next      = escape_reg;
        if (in_quote_reg) begin
            if (escape_reg) begin
                escape_next = 1'b0;
            end else if (text_byte == CHR_BSLASH) begin
                escape_next = 1'b1;
            end else if ((quote_dq_reg && text_byte == CHR_DQUOTE) ||
                         (!quote_dq_reg && text_byte == CHR_SQUOTE)) begin
                in_quote_next = 1'b0;
            end
        end else if (text_byte == CHR_DQUOTE || text_byte == CHR_SQUOTE) begin
            in_quote_next = 1'b1;
            quote_dq_next = (text_byte == CHR_DQUOTE);
        end else if (text_byte == CHR_LPAREN) begin
            if (paren_depth_reg != DEPTH_MAX) begin
                paren_depth_next = paren_depth_reg + DEPTH_ONE;
            end
        end else if (text_byte == CHR_RPAREN) begin
            if (paren_depth_reg != DEPTH_MIN) begin
                paren_depth_next = paren_depth_reg - DEPTH_ONE;
            end
        end
    end

    // last significant byte
    always_comb begin
        colon_next = colon_reg;
        if (text_byte != CHR_SPACE && text_byte != CHR_LF && text_byte != CHR_CR) begin
            colon_next = (text_byte == CHR_COLON);
        end
    end

    // indentation, blank lines leave it untouched
    always_comb begin
        line_start_next = line_start_reg;
        line_ind_next   = line_ind_reg;
        last_ind_next   = last_ind_reg;
        saw_ind_next    = saw_ind_reg;
        if (line_start_reg) begin
            if (text_byte == CHR_SPACE) begin
                line_ind_next = 1'b1;
            end else if (text_byte == CHR_LF) begin
                line_ind_next = 1'b0;
            end else begin
                line_start_next = 1'b0;
            end
        end else if (text_byte == CHR_LF) begin
            saw_ind_next    = saw_ind_reg | line_ind_reg;
            last_ind_next   = line_ind_reg;
            line_ind_next   = 1'b0;
            line_start_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && terminator)) begin
            paren_depth_reg <= '0;
            in_quote_reg    <= 1'b0;
            quote_dq_reg    <= 1'b0;
            escape_reg      <= 1'b0;
            colon_reg       <= 1'b0;
            line_start_reg  <= 1'b1;
            line_ind_reg    <= 1'b0;
            last_ind_reg    <= 1'b0;
            saw_ind_reg     <= 1'b0;
        end else if (step) begin
            paren_depth_reg <= paren_depth_next;
            in_quote_reg    <= in_quote_next;
            quote_dq_reg    <= quote_dq_next;
            escape_reg      <= escape_next;
            colon_reg       <= colon_next;
            line_start_reg  <= line_start_next;
            line_ind_reg    <= line_ind_next;
            last_ind_reg    <= last_ind_next;
            saw_ind_reg     <= saw_ind_next;
        end
    end

    `SCC_ASSERT_NOW(a_escape_in_quote, escape_reg, in_quote_reg,
        "escape pending outside a quote")
    `SCC_ASSERT_NEXT(a_clear_on_end, step && terminator,
        paren_depth_reg == '0 && !in_quote_reg && !colon_reg && line_start_reg && !saw_ind_reg,
        "state not cleared after end of buffer")
    `SCC_ASSERT_NEXT(a_depth_frozen_in_quote, step && !terminator && in_quote_reg,
        $stable(paren_depth_reg), "parenthesis depth moved inside a quote")

endmodule

`default_nettype wire

### hdl/statement_completeness_checker_core.sv
// ----------------------------------------------------------------------------
// statement_completeness_checker_core
// streams source bytes and reports on each zero byte whether the buffered
// statement is complete
//
//   channel | dir | ports                                   | moves
//   --------+-----+-----------------------------------------+-----------------
//   s_      | in  | s_valid s_ready s_text_byte             | one byte
//   m_      | out | m_valid m_ready m_complete m_why_incomplete | one verdict
//
// one byte per cycle; a byte passes an input register and the scanner, and
// the verdict of a zero byte is captured in the result register and shown on m_.
// reset clears all scanner state and empties both registers.
// only a zero byte waits, and only while the result register is still held.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "statement_completeness_checker_core_assert.svh"

module statement_completeness_checker_core
    import scc_pkg::*;
#(
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_text_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_complete,
    output logic [1:0]      m_why_incomplete
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    verdict_t   out_verdict_reg;

    verdict_t   verdict;
    logic       in_is_end;
    logic       advance;

    assign in_is_end = (in_byte_reg == CHR_NUL);
    // a zero byte needs room in the result register
    assign advance   = in_valid_reg && (!in_is_end || !out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;

    scc_scan #(
        .DEPTH_BITS(DEPTH_BITS)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .text_byte(in_byte_reg),
        .verdict  (verdict)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_text_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_is_end) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_is_end) begin
            out_verdict_reg <= verdict;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_complete       = out_verdict_reg.complete;
    assign m_why_incomplete = out_verdict_reg.why;

    `SCC_ASSERT_NEXT(a_end_gives_result, advance && in_is_end, out_valid_reg,
        "end of buffer gave no result")
    `SCC_ASSERT_NOW(a_complete_matches_code, out_valid_reg,
        out_verdict_reg.complete == (out_verdict_reg.why == WHY_COMPLETE),
        "complete flag disagrees with reason code")
    `SCC_ASSERT_NOW(a_stall_only_on_full, !s_ready,
        in_valid_reg && in_is_end && out_valid_reg && !m_ready,
        "input stalled without a held result")

endmodule

`default_nettype wire
